// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every edge outside reset
`define CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent on one edge, consequent on the next
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tes_pkg.sv =====
// Types, widths and operation codes for the triangle element stress core.
// No dependencies; used by tes_divider and triangle_element_stress_core.
package tes_pkg;

  localparam int GRAIN_COUNT = 64;
  localparam int GRAIN_W     = $clog2(GRAIN_COUNT);
  localparam int COEF_N      = 9;
  localparam int POS_W       = 24;            // Q8.16 coordinate
  localparam int DIF_W       = POS_W + 1;     // coordinate difference
  localparam int MUL_W       = DIF_W + POS_W; // difference times displacement
  localparam int DPR_W       = 2 * DIF_W;     // difference times difference
  localparam int DET_W       = DPR_W + 1;
  localparam int N_W         = MUL_W + 3;     // strain numerator, six terms
  localparam int SPLIT       = N_W / 2;
  localparam int PLO_W       = 32 + SPLIT + 1;
  localparam int PHI_W       = 32 + (N_W - SPLIT);
  localparam int P_W         = 32 + N_W;
  localparam int ACC_W       = P_W + 2;
  localparam int D_W         = DET_W;         // |det|
  localparam int QUO_W       = 33;            // quotient bits kept before clipping
  localparam int DIV_LAT     = QUO_W + 1;

  localparam logic [3:0] OP_COMPUTE    = 4'd0;
  localparam logic [3:0] OP_LOAD_FIRST = 4'd1;
  localparam logic [3:0] OP_LOAD_LAST  = 4'd9;

  typedef struct packed {
    logic [3:0]         operation;
    logic [5:0]         grain;
    logic [47:0]        node1_position;
    logic [47:0]        node2_position;
    logic [47:0]        node3_position;
    logic [47:0]        node1_displacement;
    logic [47:0]        node2_displacement;
    logic [47:0]        node3_displacement;
    logic signed [31:0] coefficient_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] stress_xx;
    logic signed [31:0] stress_yy;
    logic signed [31:0] stress_xy;
    logic               degenerate;
    logic               saturated;
  } result_t;

  // One numerator entering the divider
  typedef struct packed {
    logic             neg;
    logic             big;   // quotient is at least 2^QUO_W
    logic [ACC_W-1:0] mag;
  } div_lane_t;

endpackage

// ===== rtl/tes_divider.sv =====
// Pipelined restoring divider: three numerators over one shared |det|.
// Depends on tes_pkg. One quotient bit per stage, rounding and clipping at the end.
module tes_divider (
  input  logic                       clk,
  input  logic                       en,
  input  tes_pkg::div_lane_t         lane [3],
  input  logic [tes_pkg::D_W-1:0]    divisor,
  output logic signed [31:0]         quot [3],
  output logic                       clip [3]
);
  import tes_pkg::*;

  logic [D_W-1:0]   r   [QUO_W+1][3];
  logic [QUO_W-1:0] l   [QUO_W+1][3];
  logic [QUO_W-1:0] q   [QUO_W+1][3];
  logic             ng  [QUO_W+1][3];
  logic             bg  [QUO_W+1][3];
  logic [D_W-1:0]   dv  [QUO_W+1];

  // Stage zero: upper bits seed the remainder, lower bits shift in
  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= divisor;
      for (int i = 0; i < 3; i++) begin
        r[0][i]  <= lane[i].mag[QUO_W+D_W-1:QUO_W];
        l[0][i]  <= lane[i].mag[QUO_W-1:0];
        q[0][i]  <= '0;
        ng[0][i] <= lane[i].neg;
        bg[0][i] <= lane[i].big;
      end
    end
  end

  // One quotient bit per stage
  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        dv[s+1] <= dv[s];
        for (int i = 0; i < 3; i++) begin
          logic [D_W:0] t;
          logic         ge;
          t  = {r[s][i], l[s][i][QUO_W-1]};
          ge = t >= {1'b0, dv[s]};
          r[s+1][i]  <= ge ? D_W'(t - {1'b0, dv[s]}) : D_W'(t);
          l[s+1][i]  <= {l[s][i][QUO_W-2:0], 1'b0};
          q[s+1][i]  <= {q[s][i][QUO_W-2:0], ge};
          ng[s+1][i] <= ng[s][i];
          bg[s+1][i] <= bg[s][i];
        end
      end
    end
  end

  // Round half away from zero, then clip to signed 32 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic         rnd;
      logic [QUO_W:0] qr;
      logic         ovf;
      rnd = {r[QUO_W][i], 1'b0} >= {1'b0, dv[QUO_W]};
      qr  = {1'b0, q[QUO_W][i]} + (QUO_W+1)'(rnd);
      if (ng[QUO_W][i]) begin
        ovf = bg[QUO_W][i] || (qr > (QUO_W+1)'(33'h0_8000_0000));
        quot[i] = ovf ? 32'sh8000_0000 : $signed(32'd0 - qr[31:0]);
      end else begin
        ovf = bg[QUO_W][i] || (qr > (QUO_W+1)'(33'h0_7FFF_FFFF));
        quot[i] = ovf ? 32'sh7FFF_FFFF : $signed(qr[31:0]);
      end
      clip[i] = ovf;
    end
  end

endmodule

// ===== rtl/triangle_element_stress_core.sv =====
// Top level of the constant-strain triangle stress core.
// Depends on tes_pkg, tes_divider and assert_macros.svh.
//
//   channel | handshake                   | payload
//   item    | item_valid / item_ready     | item   (tes_pkg::item_t)
//   result  | result_valid / result_ready | result (tes_pkg::result_t)
//
// One beat per cycle in while the pipeline advances; one result per compute beat,
// through 7 arithmetic stages, 34 divider stages and the output register.
// Load beats write one of nine 64-entry coefficient banks and give no result.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is dropped or repeated.
// Reset clears only valid bits; coefficient banks hold garbage until loaded.
module triangle_element_stress_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tes_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output tes_pkg::result_t  result
);
  import tes_pkg::*;

`include "assert_macros.svh"

  logic adv;
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  // Field unpacking
  logic signed [POS_W-1:0] x1, y1, x2, y2, x3, y3, u1, v1, u2, v2, u3, v3;
  assign x1 = $signed(item.node1_position[47:24]);
  assign y1 = $signed(item.node1_position[23:0]);
  assign x2 = $signed(item.node2_position[47:24]);
  assign y2 = $signed(item.node2_position[23:0]);
  assign x3 = $signed(item.node3_position[47:24]);
  assign y3 = $signed(item.node3_position[23:0]);
  assign u1 = $signed(item.node1_displacement[47:24]);
  assign v1 = $signed(item.node1_displacement[23:0]);
  assign u2 = $signed(item.node2_displacement[47:24]);
  assign v2 = $signed(item.node2_displacement[23:0]);
  assign u3 = $signed(item.node3_displacement[47:24]);
  assign v3 = $signed(item.node3_displacement[23:0]);

  logic grain_ok, is_load, wr_en;
  logic [3:0] wr_bank;
  assign grain_ok = {1'b0, item.grain} < 7'(GRAIN_COUNT);
  assign is_load  = item.operation >= OP_LOAD_FIRST && item.operation <= OP_LOAD_LAST;
  assign wr_en    = item_valid && adv && is_load && grain_ok;
  assign wr_bank  = item.operation - OP_LOAD_FIRST;

  // Stage 1: differences, displacements, coefficient read
  logic                    s1_v, s1_ok;
  logic signed [DIF_W-1:0] dx13, dy21, dx12, dy31, db0, dc1;
  logic signed [POS_W-1:0] s1_u1, s1_v1, s1_u2, s1_v2, s1_u3, s1_v3;
  logic        [31:0]      s1_coef [COEF_N];

  for (genvar b = 0; b < COEF_N; b++) begin : g_bank
    logic [31:0] mem [GRAIN_COUNT];
    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 4'(b)) begin
        mem[item.grain[GRAIN_W-1:0]] <= item.coefficient_value;
      end
      if (adv) begin
        s1_coef[b] <= mem[item.grain[GRAIN_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx13  <= x1 - x3;
      dy21  <= y2 - y1;
      dx12  <= x1 - x2;
      dy31  <= y3 - y1;
      db0   <= y2 - y3;
      dc1   <= x3 - x2;
      s1_u1 <= u1; s1_v1 <= v1;
      s1_u2 <= u2; s1_v2 <= v2;
      s1_u3 <= u3; s1_v3 <= v3;
      s1_ok <= grain_ok;
    end
  end

  // Stage 2: products of B and displacements, area products
  logic                    s2_v;
  logic signed [MUL_W-1:0] pm [12];
  logic signed [DPR_W-1:0] pd0, pd1;
  logic signed [31:0]      s2_coef [COEF_N];

  always_ff @(posedge clk) begin
    if (adv) begin
      pm[0]  <= db0  * s1_u1;
      pm[1]  <= dy31 * s1_u2;
      pm[2]  <= dy21 * s1_u3;
      pm[3]  <= dc1  * s1_v1;
      pm[4]  <= dx13 * s1_v2;
      pm[5]  <= dx12 * s1_v3;
      pm[6]  <= dc1  * s1_u1;
      pm[7]  <= db0  * s1_v1;
      pm[8]  <= dx13 * s1_u2;
      pm[9]  <= dy31 * s1_v2;
      pm[10] <= dx12 * s1_u3;
      pm[11] <= dy21 * s1_v3;
      pd0    <= dx13 * dy21;
      pd1    <= dx12 * dy31;
      for (int j = 0; j < COEF_N; j++) begin
        s2_coef[j] <= s1_ok ? $signed(s1_coef[j]) : 32'sd0;
      end
    end
  end

  // Stage 3: strain numerators and twice the area
  logic                    s3_v;
  logic signed [N_W-1:0]   n3 [3];
  logic signed [DET_W-1:0] det3;
  logic signed [31:0]      s3_coef [COEF_N];

  always_ff @(posedge clk) begin
    if (adv) begin
      n3[0] <= N_W'(pm[0]) + N_W'(pm[1]) - N_W'(pm[2]);
      n3[1] <= N_W'(pm[3]) + N_W'(pm[4]) - N_W'(pm[5]);
      n3[2] <= N_W'(pm[6]) + N_W'(pm[7]) + N_W'(pm[8]) + N_W'(pm[9])
             - N_W'(pm[10]) - N_W'(pm[11]);
      det3  <= DET_W'(pd0) - DET_W'(pd1);
      s3_coef <= s2_coef;
    end
  end

  // Stage 4: |det| and half-width partial products of D times strain
  logic                    s4_v, s4_dg;
  logic        [D_W-1:0]   adet4;
  logic signed [PLO_W-1:0] plo [COEF_N];
  logic signed [PHI_W-1:0] phi [COEF_N];

  for (genvar j = 0; j < COEF_N; j++) begin : g_pp
    always_ff @(posedge clk) begin
      if (adv) begin
        plo[j] <= s3_coef[j] * $signed({1'b0, n3[j/3][SPLIT-1:0]});
        phi[j] <= s3_coef[j] * $signed(n3[j/3][N_W-1:SPLIT]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adet4 <= det3[DET_W-1] ? D_W'(-det3) : D_W'(det3);
      s4_dg <= det3 == '0;
    end
  end

  // Stage 5: full products
  logic                  s5_v, s5_dg;
  logic [D_W-1:0]        adet5;
  logic signed [P_W-1:0] prod [COEF_N];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < COEF_N; j++) begin
        prod[j] <= (P_W'(phi[j]) <<< SPLIT) + P_W'(plo[j]);
      end
      adet5 <= adet4;
      s5_dg <= s4_dg;
    end
  end

  // Stage 6: stress numerators, coefficient i + 3k times n_k
  logic                    s6_v, s6_dg;
  logic [D_W-1:0]          adet6;
  logic signed [ACC_W-1:0] acc [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= ACC_W'(prod[i]) + ACC_W'(prod[i+3]) + ACC_W'(prod[i+6]);
      end
      adet6 <= adet5;
      s6_dg <= s5_dg;
    end
  end

  // Stage 7: magnitude, sign, early overflow check
  logic            s7_v, s7_dg;
  logic [D_W-1:0]  adet7;
  div_lane_t       lane7 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [ACC_W-1:0] m;
        m = acc[i][ACC_W-1] ? ACC_W'(-acc[i]) : ACC_W'(acc[i]);
        lane7[i].neg <= acc[i][ACC_W-1];
        lane7[i].mag <= m;
        lane7[i].big <= m >= ACC_W'({adet6, QUO_W'(0)});
      end
      adet7 <= adet6;
      s7_dg <= s6_dg;
    end
  end

  // Valid bits for the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0;
      s5_v <= 1'b0; s6_v <= 1'b0; s7_v <= 1'b0;
    end else if (adv) begin
      s1_v <= item_valid && item.operation == OP_COMPUTE;
      s2_v <= s1_v; s3_v <= s2_v; s4_v <= s3_v;
      s5_v <= s4_v; s6_v <= s5_v; s7_v <= s6_v;
    end
  end

  // Divider and its matching valid/degenerate line
  logic signed [31:0] quot [3];
  logic               clip [3];
  logic [DIV_LAT-1:0] dv_line, dg_line;

  tes_divider u_div (
    .clk     (clk),
    .en      (adv),
    .lane    (lane7),
    .divisor (adet7),
    .quot    (quot),
    .clip    (clip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_line <= '0;
    end else if (adv) begin
      dv_line <= {dv_line[DIV_LAT-2:0], s7_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dg_line <= {dg_line[DIV_LAT-2:0], s7_dg};
    end
  end

  // Output register
  logic out_dg;
  assign out_dg = dg_line[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv_line[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.stress_xx  <= out_dg ? 32'sd0 : quot[0];
      result.stress_yy  <= out_dg ? 32'sd0 : quot[1];
      result.stress_xy  <= out_dg ? 32'sd0 : quot[2];
      result.degenerate <= out_dg;
      result.saturated  <= !out_dg && (clip[0] || clip[1] || clip[2]);
    end
  end

  // Checks
  `CHK(a_degen_zero, (result_valid && result.degenerate) |-> (result.stress_xx == 0 && result.stress_yy == 0 && result.stress_xy == 0 && !result.saturated), "degenerate result carries nonzero stress")
  `CHK_NEXT(a_load_no_result, item_valid && item_ready && item.operation != OP_COMPUTE, !s1_v, "non-compute beat entered the datapath")
  `CHK(a_sat_limit, (result_valid && result.saturated) |-> (result.stress_xx == 32'sh7FFF_FFFF || result.stress_xx == 32'sh8000_0000 || result.stress_yy == 32'sh7FFF_FFFF || result.stress_yy == 32'sh8000_0000 || result.stress_xy == 32'sh7FFF_FFFF || result.stress_xy == 32'sh8000_0000), "saturated flag without a clipped stress")

endmodule
